// ===== rtl/mmba_pkg.sv =====
package mmba_pkg;

  // Defaults for the top-level parameters.
  localparam int ROM_ADDR_BITS_DEF  = 25;
  localparam int SAVE_ADDR_BITS_DEF = 16;

  // Data path geometry. Every region is stored as 32-bit words, four byte lanes.
  localparam int BYTE_W         = 8;
  localparam int BYTES_PER_WORD = 4;
  localparam int WORD_W         = BYTE_W * BYTES_PER_WORD;
  localparam int ADDR_W         = 32;

  // Stream payload widths (packed fields, padded to whole bytes).
  localparam int IN_FIELDS_W  = 2 + 2 + 3 * ADDR_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = WORD_W + 2;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Word depths and word-index widths of the fixed regions.
  localparam int BOOT_WORDS = 4096;
  localparam int BOOT_AW    = 12;
  localparam int EXT_WORDS  = 65536;
  localparam int EXT_AW     = 16;
  localparam int INT_WORDS  = 8192;
  localparam int INT_AW     = 13;
  localparam int PAL_WORDS  = 256;
  localparam int PAL_AW     = 8;
  localparam int VRAM_WORDS = 24576;
  localparam int VRAM_AW    = 15;
  localparam int OAM_WORDS  = 256;
  localparam int OAM_AW     = 8;

  // The clearing sweep walks the deepest cleared region.
  localparam int CLR_AW = EXT_AW;

  // Opcodes.
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_PRELOAD = 2'd2;

  // Access sizes.
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // Top address byte of each region.
  localparam logic [7:0] REG_BOOT    = 8'h00;
  localparam logic [7:0] REG_EXT     = 8'h02;
  localparam logic [7:0] REG_INT     = 8'h03;
  localparam logic [7:0] REG_IO      = 8'h04;
  localparam logic [7:0] REG_PAL     = 8'h05;
  localparam logic [7:0] REG_VRAM    = 8'h06;
  localparam logic [7:0] REG_OAM     = 8'h07;
  localparam logic [7:0] REG_CART0   = 8'h08;
  localparam logic [7:0] REG_CART1   = 8'h09;
  localparam logic [7:0] REG_CART2   = 8'h0a;
  localparam logic [7:0] REG_CART3   = 8'h0b;
  localparam logic [7:0] REG_CART4   = 8'h0c;
  localparam logic [7:0] REG_CART5   = 8'h0d;
  localparam logic [7:0] REG_SAVE0   = 8'h0e;
  localparam logic [7:0] REG_SAVE1   = 8'h0f;

  localparam logic [ADDR_W-1:0] BOOT_PC_LIMIT = 32'h3fff + 32'd8;
  localparam logic [16:0]       VRAM_FOLD_TOP = 17'h17fff;
  localparam logic [16:0]       VRAM_FOLD_SUB = 17'h08000;

  // Where the bytes of a read come from.
  typedef enum logic [3:0] {
    SRC_BOOT,
    SRC_EXT,
    SRC_INT,
    SRC_PAL,
    SRC_VRAM,
    SRC_OAM,
    SRC_CART,
    SRC_SAVE,
    SRC_FILL_FF,
    SRC_FILL_00
  } src_t;

endpackage

// ===== rtl/mmba_ram.sv =====
module mmba_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [mmba_pkg::BYTES_PER_WORD-1:0] we,
  input  logic [AW-1:0]                      addr,
  input  logic [mmba_pkg::WORD_W-1:0]        wdata,
  output logic [mmba_pkg::WORD_W-1:0]        rdata
);
  import mmba_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // Byte-enabled write, registered read; the read returns the old word.
  always_ff @(posedge clk) begin
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      if (we[b]) begin
        mem[addr][b*BYTE_W +: BYTE_W] <= wdata[b*BYTE_W +: BYTE_W];
      end
    end
    if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/memory_map_bus_access.sv =====
// Bus access decoder for a console memory map. Each input transfer is one
// byte, halfword or word read, write or preload; the address is forced to
// the alignment of the size. The top address byte picks the region: boot
// ROM (0x00), external RAM (0x02), internal RAM (0x03), I/O (0x04, only
// flagged), palette (0x05), VRAM (0x06, upper 32K folded down), OAM (0x07),
// cartridge ROM (0x08-0x0d) and save RAM (0x0e-0x0f), with mirroring by
// masking. Unmapped or refused bytes read 0xff, I/O bytes read 0x00 so an
// outside block can merge its data. Boot ROM reads need the PC at most
// eight past the boot ROM. Plain writes to the ROMs are dropped; a preload
// fills them. Every region is a word-wide memory with byte enables, and an
// aligned access never leaves one word, so each access is a single memory
// operation. After reset a clearing sweep zeroes the RAM regions, one word
// per cycle; no input transfer is taken while it runs. After that the block
// takes one transfer per cycle while the output is not stalled: the memory
// read in the accept cycle returns its word in the next cycle, and the
// result is then held in an output register. An undefined opcode makes no
// access. Every transfer produces exactly one result transfer.
module memory_map_bus_access #(
  parameter int ROM_ADDR_BITS  = mmba_pkg::ROM_ADDR_BITS_DEF,
  parameter int SAVE_ADDR_BITS = mmba_pkg::SAVE_ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input transfer, from the lowest bit up: opcode[1:0], access_size[1:0],
  // address[31:0], write_data[31:0], program_counter[31:0], zero padding.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mmba_pkg::IN_TDATA_W-1:0]  s_tdata,
  // Result transfer, from the lowest bit up: read_data[31:0], io_touched,
  // boot_read_blocked, zero padding.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mmba_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import mmba_pkg::*;

  localparam int ROM_AW    = ROM_ADDR_BITS - 2;
  localparam int SAVE_AW   = SAVE_ADDR_BITS - 2;
  localparam int ROM_WORDS  = 2 ** ROM_AW;
  localparam int SAVE_WORDS = 2 ** SAVE_AW;

  // Input fields.
  logic [1:0]        opcode;
  logic [1:0]        access_size;
  logic [ADDR_W-1:0] address;
  logic [WORD_W-1:0] write_data;
  logic [ADDR_W-1:0] program_counter;

  assign opcode          = s_tdata[1:0];
  assign access_size     = s_tdata[3:2];
  assign address         = s_tdata[4 +: ADDR_W];
  assign write_data      = s_tdata[4 + ADDR_W +: WORD_W];
  assign program_counter = s_tdata[4 + ADDR_W + WORD_W +: ADDR_W];

  // Clearing sweep after reset.
  logic              clearing;
  logic [CLR_AW-1:0] clr_cnt;

  // Pipeline control: stage one waits on the memory word, then the output.
  logic s1_valid;
  logic s1_move;
  logic accept;
  logic out_valid;

  assign s1_move  = !out_valid || m_tready;
  assign s_tready = !clearing && (!s1_valid || s1_move);
  assign accept   = s_tvalid && s_tready;

  // Access decode.
  logic [ADDR_W-1:0]         addr_al;
  logic [BYTES_PER_WORD-1:0] lane_mask;
  logic [1:0]                shift;
  logic [WORD_W-1:0]         wdata_word;
  logic [7:0]                region;
  logic                      op_valid;
  logic                      is_read;
  logic                      is_wr;
  logic                      is_preload;
  logic                      boot_off_ok;
  logic                      io_hit;
  logic                      blocked;
  logic [16:0]               vram_off;
  src_t                      src;

  always_comb begin
    unique case (access_size)
      SIZE_BYTE: begin
        addr_al   = address;
        lane_mask = 4'b0001 << address[1:0];
      end
      SIZE_HALF: begin
        addr_al   = {address[ADDR_W-1:1], 1'b0};
        lane_mask = 4'b0011 << {address[1], 1'b0};
      end
      default: begin
        addr_al   = {address[ADDR_W-1:2], 2'b00};
        lane_mask = 4'b1111;
      end
    endcase
  end

  assign shift      = addr_al[1:0];
  assign wdata_word = write_data << {shift, 3'b000};
  assign region     = addr_al[31:24];
  assign op_valid   = (opcode == OP_READ) || (opcode == OP_WRITE) || (opcode == OP_PRELOAD);
  assign is_read    = opcode == OP_READ;
  assign is_preload = opcode == OP_PRELOAD;
  assign is_wr      = accept && ((opcode == OP_WRITE) || is_preload);
  assign boot_off_ok = (region == REG_BOOT) && (addr_al[23:14] == '0);
  assign io_hit     = op_valid && (region == REG_IO) && (addr_al[23:10] == '0);
  assign vram_off   = (addr_al[16:0] > VRAM_FOLD_TOP) ? addr_al[16:0] - VRAM_FOLD_SUB
                                                      : addr_al[16:0];

  always_comb begin
    blocked = 1'b0;
    case (region) inside
      REG_BOOT: begin
        if (boot_off_ok && program_counter <= BOOT_PC_LIMIT) begin
          src = SRC_BOOT;
        end else begin
          src     = SRC_FILL_FF;
          blocked = is_read;
        end
      end
      REG_EXT:  src = SRC_EXT;
      REG_INT:  src = SRC_INT;
      REG_IO:   src = (addr_al[23:10] == '0) ? SRC_FILL_00 : SRC_FILL_FF;
      REG_PAL:  src = SRC_PAL;
      REG_VRAM: src = SRC_VRAM;
      REG_OAM:  src = SRC_OAM;
      REG_CART0, REG_CART1, REG_CART2, REG_CART3, REG_CART4, REG_CART5:
        src = SRC_CART;
      REG_SAVE0, REG_SAVE1:
        src = SRC_SAVE;
      default:  src = SRC_FILL_FF;
    endcase
  end

  // Per-region write enables. During the sweep every cleared region writes
  // zeros at the sweep index while it is within its depth.
  logic [BYTES_PER_WORD-1:0] lanes_wr;
  assign lanes_wr = is_wr ? lane_mask : '0;

  logic [BYTES_PER_WORD-1:0] boot_we, ext_we, int_we, pal_we, vram_we, oam_we, cart_we, save_we;
  logic [WORD_W-1:0]         ram_wdata;

  assign ram_wdata = clearing ? '0 : wdata_word;
  assign boot_we = (!clearing && is_preload && boot_off_ok) ? lanes_wr : '0;
  assign cart_we = (!clearing && is_preload && src == SRC_CART) ? lanes_wr : '0;
  assign ext_we  = clearing ? '1 : ((src == SRC_EXT) ? lanes_wr : '0);
  assign int_we  = clearing ? {BYTES_PER_WORD{{1'b0, clr_cnt} < (CLR_AW+1)'(INT_WORDS)}}
                            : ((src == SRC_INT) ? lanes_wr : '0);
  assign pal_we  = clearing ? {BYTES_PER_WORD{{1'b0, clr_cnt} < (CLR_AW+1)'(PAL_WORDS)}}
                            : ((src == SRC_PAL) ? lanes_wr : '0);
  assign vram_we = clearing ? {BYTES_PER_WORD{{1'b0, clr_cnt} < (CLR_AW+1)'(VRAM_WORDS)}}
                            : ((src == SRC_VRAM) ? lanes_wr : '0);
  assign oam_we  = clearing ? {BYTES_PER_WORD{{1'b0, clr_cnt} < (CLR_AW+1)'(OAM_WORDS)}}
                            : ((src == SRC_OAM) ? lanes_wr : '0);
  assign save_we = clearing ? {BYTES_PER_WORD{{1'b0, clr_cnt} < (CLR_AW+1)'(SAVE_WORDS)}}
                            : ((src == SRC_SAVE) ? lanes_wr : '0);

  // Word indexes (region mask, then drop the byte offset).
  logic [EXT_AW-1:0]  ext_addr;
  logic [INT_AW-1:0]  int_addr;
  logic [PAL_AW-1:0]  pal_addr;
  logic [VRAM_AW-1:0] vram_addr;
  logic [OAM_AW-1:0]  oam_addr;
  logic [SAVE_AW-1:0] save_addr;

  assign ext_addr  = clearing ? clr_cnt[EXT_AW-1:0]  : addr_al[EXT_AW+1:2];
  assign int_addr  = clearing ? clr_cnt[INT_AW-1:0]  : addr_al[INT_AW+1:2];
  assign pal_addr  = clearing ? clr_cnt[PAL_AW-1:0]  : addr_al[PAL_AW+1:2];
  assign vram_addr = clearing ? clr_cnt[VRAM_AW-1:0] : vram_off[VRAM_AW+1:2];
  assign oam_addr  = clearing ? clr_cnt[OAM_AW-1:0]  : addr_al[OAM_AW+1:2];
  assign save_addr = clearing ? clr_cnt[SAVE_AW-1:0] : addr_al[SAVE_AW+1:2];

  logic [WORD_W-1:0] boot_rd, ext_rd, int_rd, pal_rd, vram_rd, oam_rd, cart_rd, save_rd;

  mmba_ram #(.DEPTH(BOOT_WORDS), .AW(BOOT_AW)) u_boot (
    .clk(clk), .en(accept), .we(boot_we), .addr(addr_al[BOOT_AW+1:2]),
    .wdata(ram_wdata), .rdata(boot_rd));
  mmba_ram #(.DEPTH(EXT_WORDS), .AW(EXT_AW)) u_ext (
    .clk(clk), .en(accept), .we(ext_we), .addr(ext_addr),
    .wdata(ram_wdata), .rdata(ext_rd));
  mmba_ram #(.DEPTH(INT_WORDS), .AW(INT_AW)) u_int (
    .clk(clk), .en(accept), .we(int_we), .addr(int_addr),
    .wdata(ram_wdata), .rdata(int_rd));
  mmba_ram #(.DEPTH(PAL_WORDS), .AW(PAL_AW)) u_pal (
    .clk(clk), .en(accept), .we(pal_we), .addr(pal_addr),
    .wdata(ram_wdata), .rdata(pal_rd));
  mmba_ram #(.DEPTH(VRAM_WORDS), .AW(VRAM_AW)) u_vram (
    .clk(clk), .en(accept), .we(vram_we), .addr(vram_addr),
    .wdata(ram_wdata), .rdata(vram_rd));
  mmba_ram #(.DEPTH(OAM_WORDS), .AW(OAM_AW)) u_oam (
    .clk(clk), .en(accept), .we(oam_we), .addr(oam_addr),
    .wdata(ram_wdata), .rdata(oam_rd));
  mmba_ram #(.DEPTH(ROM_WORDS), .AW(ROM_AW)) u_cart (
    .clk(clk), .en(accept), .we(cart_we), .addr(addr_al[ROM_AW+1:2]),
    .wdata(ram_wdata), .rdata(cart_rd));
  mmba_ram #(.DEPTH(SAVE_WORDS), .AW(SAVE_AW)) u_save (
    .clk(clk), .en(accept), .we(save_we), .addr(save_addr),
    .wdata(ram_wdata), .rdata(save_rd));

  // Stage one: decode results that travel alongside the memory read.
  src_t                      s1_src;
  logic [1:0]                s1_shift;
  logic [BYTES_PER_WORD-1:0] s1_keep;
  logic                      s1_read;
  logic                      s1_io;
  logic                      s1_blocked;

  // Output register.
  logic [WORD_W-1:0] out_read_data;
  logic              out_io;
  logic              out_blocked;

  // Read word select and lane extraction.
  logic [WORD_W-1:0] src_word;
  logic [WORD_W-1:0] keep_mask;
  logic [WORD_W-1:0] lane_data;

  always_comb begin
    case (s1_src)
      SRC_BOOT:    src_word = boot_rd;
      SRC_EXT:     src_word = ext_rd;
      SRC_INT:     src_word = int_rd;
      SRC_PAL:     src_word = pal_rd;
      SRC_VRAM:    src_word = vram_rd;
      SRC_OAM:     src_word = oam_rd;
      SRC_CART:    src_word = cart_rd;
      SRC_SAVE:    src_word = save_rd;
      SRC_FILL_00: src_word = '0;
      default:     src_word = '1;
    endcase
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      keep_mask[b*BYTE_W +: BYTE_W] = {BYTE_W{s1_keep[b]}};
    end
    lane_data = s1_read ? ((src_word >> {s1_shift, 3'b000}) & keep_mask) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == '1) begin
          clearing <= 1'b0;
        end
      end
      if (s_tready) begin
        s1_valid <= accept;
      end
      if (s1_move) begin
        out_valid <= s1_valid;
      end
    end
    if (accept) begin
      s1_src     <= src;
      s1_shift   <= shift;
      s1_read    <= is_read;
      s1_io      <= io_hit;
      s1_blocked <= blocked;
      unique case (access_size)
        SIZE_BYTE: s1_keep <= 4'b0001;
        SIZE_HALF: s1_keep <= 4'b0011;
        default:   s1_keep <= 4'b1111;
      endcase
    end
    if (s1_valid && s1_move) begin
      out_read_data <= lane_data;
      out_io        <= s1_io;
      out_blocked   <= s1_blocked;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_blocked, out_io, out_read_data};

  // A refused boot read always shows 0xff in its first lane.
  a_blocked_ff: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[WORD_W+1] |-> m_tdata[BYTE_W-1:0] == 8'hff)
    else $error("refused boot read without 0xff fill");

  // I/O and boot ROM are different regions; both flags cannot be set.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[WORD_W] && m_tdata[WORD_W+1]))
    else $error("io and boot-blocked flags set together");

  // No transfer is taken while the clearing sweep runs.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input ready during clearing sweep");

  // A stage-one item that cannot move on is kept, not dropped.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_src))
    else $error("stalled stage-one item lost");

endmodule

// ===== tb/tb_memory_map_bus_access.sv =====
module tb_memory_map_bus_access;
  timeunit 1ns;
  timeprecision 1ps;

  import mmba_pkg::*;

  // Codes the package does not name: the undefined opcode and the two word sizes.
  localparam logic [1:0] OP_NONE   = 2'd3;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_RSVD = 2'd3;

  localparam logic [31:0] BOOT_TOP  = 32'h3fff;
  localparam logic [31:0] ROM_MASK  = (32'd1 << ROM_ADDR_BITS_DEF) - 32'd1;
  localparam logic [31:0] SAVE_MASK = (32'd1 << SAVE_ADDR_BITS_DEF) - 32'd1;

  localparam int RANDOM_ACCESSES = 1300;
  localparam int PAUSE_AT        = 800;    // sender drains the block here
  localparam int LONG_HOLD_AT    = 400;    // receiver stalls after this many results
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_CYCLES    = 16;
  // The limit covers the clearing sweep and the rest of the slowest run with
  // a wide margin.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP = 200;

  // One bus access. Packed so that the lowest field lands in the lowest bits,
  // which is exactly the s_tdata layout.
  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] wdata;
    logic [31:0] addr;
    logic [1:0]  size;
    logic [1:0]  op;
  } access_t;

  // One bus result, laid out as the low bits of m_tdata.
  typedef struct packed {
    logic        blk;
    logic        io;
    logic [31:0] rd;
  } bus_result_t;

  // An access as it is offered, with the result typed in where it is obvious.
  typedef struct {
    access_t     acc;
    bit          fixed;
    bus_result_t want;
  } offer_t;

  // Directed rows, written in field order: op, size, addr, wdata, pc, fixed,
  // then read_data, io_touched, boot_read_blocked for the fixed rows.
  typedef struct {
    logic [1:0]  op;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [31:0] pc;
    bit          fixed;
    logic [31:0] rd;
    logic        io;
    logic        blk;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // RAM reads zero right after the clearing sweep.
    '{OP_READ,    SIZE_WORD, 32'h0200_0000, 32'h0,         32'h0,         1, 32'h0,        0, 0},
    // Top of the address space is unmapped.
    '{OP_READ,    SIZE_WORD, 32'hffff_ffff, 32'h0,         32'h0,         1, 32'hffff_ffff, 0, 0},
    // Boot ROM offset past its end is refused even with a good PC.
    '{OP_READ,    SIZE_BYTE, 32'h0000_4000, 32'h0,         32'h0,         1, 32'h0000_00ff, 0, 1},
    // I/O bytes read zero and raise the flag; just past the I/O range is unmapped.
    '{OP_READ,    SIZE_WORD, 32'h0400_0000, 32'h0,         32'h0,         1, 32'h0,        1, 0},
    '{OP_READ,    SIZE_WORD, 32'h0400_0400, 32'h0,         32'h0,         1, 32'hffff_ffff, 0, 0},
    '{OP_READ,    SIZE_HALF, 32'h0400_03ff, 32'h0,         32'h0,         1, 32'h0,        1, 0},
    // Undefined opcode: no access at all, not even the I/O flag.
    '{OP_NONE,    SIZE_WORD, 32'h0400_0000, 32'hffff_ffff, 32'hffff_ffff, 1, 32'h0,        0, 0},
    // Boot ROM preloads, the last one beyond the ROM and so dropped.
    '{OP_PRELOAD, SIZE_WORD, 32'h0000_0000, 32'h0123_4567, 32'h0,         1, 32'h0,        0, 0},
    '{OP_PRELOAD, SIZE_WORD, 32'h0000_3ffc, 32'ha5a5_ffff, 32'h0,         1, 32'h0,        0, 0},
    '{OP_PRELOAD, SIZE_WORD, 32'h0000_4000, 32'hffff_ffff, 32'h0,         1, 32'h0,        0, 0},
    // PC exactly at the limit is allowed, one above it is refused.
    '{OP_READ,    SIZE_WORD, 32'h0000_3ffe, 32'h0,         32'h0000_4007, 0, 32'h0,        0, 0},
    '{OP_READ,    SIZE_HALF, 32'h0000_0002, 32'h0,         32'h0000_4008, 1, 32'h0000_ffff, 0, 1},
    // A plain write to the boot ROM is dropped; the read shows the preload.
    '{OP_WRITE,   SIZE_WORD, 32'h0000_0000, 32'h0,         32'h0,         1, 32'h0,        0, 0},
    '{OP_READ,    SIZE_WORD, 32'h0000_0001, 32'h0,         32'h0,         0, 32'h0,        0, 0},
    // Cartridge ROM: preload, dropped write through a mirror, mirrored reads.
    '{OP_PRELOAD, SIZE_WORD, 32'h0800_0000, 32'hdead_beef, 32'h0,         1, 32'h0,        0, 0},
    '{OP_WRITE,   SIZE_WORD, 32'h0a00_0000, 32'h0,         32'h0,         1, 32'h0,        0, 0},
    '{OP_READ,    SIZE_BYTE, 32'h0c00_0003, 32'h0,         32'h0,         0, 32'h0,        0, 0},
    '{OP_PRELOAD, SIZE_WORD, 32'h0dff_fffc, 32'h89ab_cdef, 32'h0,         1, 32'h0,        0, 0},
    '{OP_READ,    SIZE_RSVD, 32'h09ff_ffff, 32'h0,         32'h0,         0, 32'h0,        0, 0},
    // VRAM above 0x17fff folds down by 32K.
    '{OP_WRITE,   SIZE_WORD, 32'h0601_8000, 32'hcafe_f00d, 32'h0,         1, 32'h0,        0, 0},
    '{OP_READ,    SIZE_WORD, 32'h0601_0000, 32'h0,         32'h0,         0, 32'h0,        0, 0},
    // Save RAM at its top, read back through the other mirror with size 3.
    '{OP_WRITE,   SIZE_HALF, 32'h0e00_ffff, 32'h1234_beef, 32'h0,         1, 32'h0,        0, 0},
    '{OP_READ,    SIZE_RSVD, 32'h0f00_fffd, 32'h0,         32'h0,         0, 32'h0,        0, 0},
    // A preload into RAM behaves as a write; read back through a mirror.
    '{OP_PRELOAD, SIZE_WORD, 32'h023f_fffc, 32'h1122_3344, 32'h0,         1, 32'h0,        0, 0},
    '{OP_READ,    SIZE_WORD, 32'h0203_fffc, 32'h0,         32'h0,         0, 32'h0,        0, 0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  memory_map_bus_access dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // The access currently on the input side; read by the monitor on accept.
  offer_t offer;

  // Byte-wide image of every storage region, keyed by a region tag in the top
  // nibble and the byte index below it. A missing entry reads as zero, which
  // matches the cleared RAMs; ROM entries are only read once preloaded.
  logic [7:0]  mem_image [logic [31:0]];
  // Fully preloaded ROM words, the pool that ROM reads are drawn from.
  logic [31:0] loaded_rom_words [$];
  bus_result_t pending_results [$];

  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int          delivered = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    // Only the first 200 are printed; all of them are counted.
    if (mismatches < PRINT_CAP)
      $display("MISMATCH %s: expected %h, got %h (cycle %0d)", what, want, got,
               cycle_count);
    mismatches++;
  endtask

  // Aligned base address and number of byte lanes of an access.
  function automatic void access_span(input access_t t, output logic [31:0] base,
                                      output int lanes);
    if (t.size == SIZE_BYTE) begin
      base  = t.addr;
      lanes = 1;
    end else if (t.size == SIZE_HALF) begin
      base  = {t.addr[31:1], 1'b0};
      lanes = 2;
    end else begin
      base  = {t.addr[31:2], 2'b00};
      lanes = 4;
    end
  endfunction

  // Maps one byte address to its storage key. Returns 0 for bytes that have
  // no storage here: unmapped, I/O, or boot ROM past its end.
  function automatic bit storage_key(input logic [31:0] a, output logic [31:0] key);
    key = '0;
    storage_key = 1'b1;
    case (a[31:24])
      REG_BOOT: begin
        key = {REG_BOOT[3:0], 28'h0} | (a & BOOT_TOP);
        storage_key = (a <= BOOT_TOP);
      end
      REG_EXT:  key = {REG_EXT[3:0], 28'h0} | (a & 32'h3ffff);
      REG_INT:  key = {REG_INT[3:0], 28'h0} | (a & 32'h7fff);
      REG_PAL:  key = {REG_PAL[3:0], 28'h0} | (a & 32'h3ff);
      REG_VRAM: begin
        key = a & 32'h1ffff;
        if (key > 32'h17fff)
          key = key - 32'h8000;
        key = key | {REG_VRAM[3:0], 28'h0};
      end
      REG_OAM:  key = {REG_OAM[3:0], 28'h0} | (a & 32'h3ff);
      REG_CART0, REG_CART1, REG_CART2, REG_CART3, REG_CART4, REG_CART5:
        key = {REG_CART0[3:0], 28'h0} | (a & ROM_MASK);
      REG_SAVE0, REG_SAVE1:
        key = {REG_SAVE0[3:0], 28'h0} | (a & SAVE_MASK);
      default:  storage_key = 1'b0;
    endcase
  endfunction

  function automatic bit is_rom_key(input logic [31:0] key);
    return key[31:28] == REG_BOOT[3:0] || key[31:28] == REG_CART0[3:0];
  endfunction

  // Works out the result of one accepted access and applies its stores to
  // the memory image.
  function automatic bus_result_t bus_access_result(input access_t t);
    bus_result_t r;
    logic [31:0] base, a, key;
    logic [7:0]  b;
    int          lanes;
    bit          hit, io_byte;
    r = '0;
    access_span(t, base, lanes);
    if (t.op == OP_NONE)
      return r;
    for (int k = 0; k < lanes; k++) begin
      a = base + k;
      io_byte = (a[31:24] == REG_IO) && (a[23:0] <= 24'h3ff);
      if (io_byte)
        r.io = 1'b1;
      hit = storage_key(a, key);
      if (t.op == OP_READ) begin
        if (a[31:24] == REG_BOOT && !(hit && t.pc <= BOOT_PC_LIMIT)) begin
          b = 8'hff;
          r.blk = 1'b1;
        end else if (a[31:24] == REG_IO) begin
          b = io_byte ? 8'h00 : 8'hff;
        end else if (hit) begin
          b = mem_image.exists(key) ? mem_image[key] : 8'h00;
        end else begin
          b = 8'hff;
        end
        r.rd[8*k +: 8] = b;
      end else if (hit && (t.op == OP_PRELOAD || !is_rom_key(key))) begin
        mem_image[key] = t.wdata[8*k +: 8];
      end
    end
    // A whole ROM word is now known, so reads may be aimed at it.
    if (t.op == OP_PRELOAD && lanes == 4 && storage_key(base, key) && is_rom_key(key))
      loaded_rom_words.push_back(base);
    return r;
  endfunction

  // True unless the access would read a ROM byte that was never preloaded.
  function automatic bit reads_known_rom(input access_t t);
    logic [31:0] base, a, key;
    int          lanes;
    access_span(t, base, lanes);
    if (t.op != OP_READ)
      return 1'b1;
    for (int k = 0; k < lanes; k++) begin
      a = base + k;
      if (storage_key(a, key) && is_rom_key(key) && !mem_image.exists(key)) begin
        // A boot ROM read with the PC outside is refused before any lookup.
        if (!(a[31:24] == REG_BOOT && t.pc > BOOT_PC_LIMIT))
          return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Random address, mostly near the ends of a region (and the VRAM fold) so
  // that writes and later reads meet, with mirror bits left random.
  function automatic logic [31:0] random_address();
    logic [7:0]  top;
    logic [23:0] low, mask, hot;
    if ($urandom_range(0, 99) < 6)
      return $urandom();
    case ($urandom_range(0, 12))
      0, 12:   top = REG_BOOT;
      1:       top = 8'h01;
      2:       top = REG_EXT;
      3:       top = REG_INT;
      4:       top = REG_IO;
      5:       top = REG_PAL;
      6:       top = REG_VRAM;
      7:       top = REG_OAM;
      8, 9:    top = REG_CART0 + 8'($urandom_range(0, 5));
      10:      top = REG_SAVE0 + 8'($urandom_range(0, 1));
      default: top = 8'h10 + 8'($urandom_range(0, 8'hef));
    endcase
    case (top)
      REG_BOOT:             mask = 24'h3fff;
      REG_EXT:              mask = 24'h3ffff;
      REG_INT:              mask = 24'h7fff;
      REG_IO, REG_PAL, REG_OAM: mask = 24'h3ff;
      REG_VRAM:             mask = 24'h1ffff;
      REG_SAVE0, REG_SAVE1: mask = 24'hffff;
      default:              mask = 24'hffffff;
    endcase
    low = 24'($urandom());
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 2))
        0:       hot = 24'($urandom_range(0, 31));
        1:       hot = mask - 24'($urandom_range(0, 31));
        default: hot = (top == REG_VRAM && $urandom_range(0, 1) == 0) ?
                       24'h17ff0 + 24'($urandom_range(0, 31)) :
                       24'h0fff0 + 24'($urandom_range(0, 31));
      endcase
      low = (low & ~mask) | (hot & mask);
    end
    if (top == REG_BOOT && $urandom_range(0, 3) != 0)
      low = low & mask;
    return {top, low};
  endfunction

  function automatic access_t random_access();
    access_t     t;
    logic [31:0] w;
    int          r;
    r = $urandom_range(0, 99);
    t.op = (r < 44) ? OP_READ : (r < 78) ? OP_WRITE : (r < 96) ? OP_PRELOAD : OP_NONE;
    t.size = ($urandom_range(0, 9) == 0) ? SIZE_RSVD : 2'($urandom_range(0, 2));
    t.addr = random_address();
    t.wdata = $urandom();
    r = $urandom_range(0, 9);
    if (r < 6)
      t.pc = $urandom_range(0, 32'h4007);
    else if (r == 6)
      t.pc = BOOT_PC_LIMIT + 32'($urandom_range(0, 1));
    else
      t.pc = $urandom();
    // Reads that would hit unknown ROM bytes are aimed at a preloaded word,
    // through a random mirror for the cartridge.
    if (!reads_known_rom(t)) begin
      w = loaded_rom_words[$urandom_range(0, loaded_rom_words.size() - 1)];
      if (w[31:24] != REG_BOOT)
        w[31:24] = REG_CART0 + {7'd0, w[24]} + 8'(2 * $urandom_range(0, 2));
      t.addr = w | 32'($urandom_range(0, 3));
    end
    return t;
  endfunction

  // Result side is checked first, then the accepted access is predicted.
  // Outputs are registered, so a result never belongs to an access accepted
  // at the same edge.
  always @(posedge clk) begin : bus_monitor
    bus_result_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(bus_result_t)-1:0];
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", '0, got.rd);
        end else begin
          want = pending_results.pop_front();
          if (got.rd !== want.rd)
            report_mismatch("read_data", want.rd, got.rd);
          if (got.io !== want.io)
            report_mismatch("io_touched", 32'(want.io), 32'(got.io));
          if (got.blk !== want.blk)
            report_mismatch("boot_read_blocked", 32'(want.blk), 32'(got.blk));
        end
      end
      if (s_tvalid && s_tready) begin
        want = bus_access_result(offer.acc);
        if (offer.fixed)
          want = offer.want;
        pending_results.push_back(want);
      end
    end
  end

  // Result receiver: random stalls per transfer, stretches with none, and one
  // long hold-off so that the block backs up and stops taking input.
  initial begin : result_receiver
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = (delivered % 170 < 35) ? 0 : $urandom_range(0, 6);
      if (delivered == LONG_HOLD_AT)
        hold = LONG_HOLD;
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      delivered++;
      @(negedge clk);
    end
  end

  // Offers one access after a random gap and holds it until it is taken.
  // Returns at the falling edge after the accepting edge.
  task automatic send_access(input offer_t o, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(o.acc);
    offer    <= o;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  initial begin : access_sender
    offer_t o;
    @(negedge clk);
    while (rst) @(negedge clk);

    foreach (directed_rows[i]) begin
      o.acc.op    = directed_rows[i].op;
      o.acc.size  = directed_rows[i].size;
      o.acc.addr  = directed_rows[i].addr;
      o.acc.wdata = directed_rows[i].wdata;
      o.acc.pc    = directed_rows[i].pc;
      o.fixed     = directed_rows[i].fixed;
      o.want      = '{blk: directed_rows[i].blk, io: directed_rows[i].io,
                      rd: directed_rows[i].rd};
      send_access(o, i % 2 == 0);
    end

    o.fixed = 1'b0;
    o.want  = '0;
    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      // Once, let the block run completely dry before going on.
      if (i == PAUSE_AT) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
      end
      o.acc = random_access();
      send_access(o, i % 200 < 40);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    // Any extra result that shows up during the drain is caught here.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
